// ===== src/cpvc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Cartesian PID velocity command block.
`default_nettype none
package cpvc_pkg;

	localparam int AXES   = 3;
	localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

	localparam int POS_W  = 24;
	localparam int ERR_W  = 25;
	localparam int DERR_W = 26;
	localparam int SUM_W  = 40;
	localparam int SMTH_W = 32;
	localparam int PID_W  = 50;
	localparam int PROD_W = 66;
	localparam int MUL_W  = 25;
	localparam int NORM_W = 51;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 3;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_ALPHA = 3'd3,
		REG_DB    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] target_x;
		logic signed [POS_W-1:0] target_y;
		logic signed [POS_W-1:0] target_z;
		logic signed [POS_W-1:0] measured_x;
		logic signed [POS_W-1:0] measured_y;
		logic signed [POS_W-1:0] measured_z;
		logic signed [POS_W-1:0] feedforward_x;
		logic signed [POS_W-1:0] feedforward_y;
		logic signed [POS_W-1:0] feedforward_z;
		logic                    enable;
		logic                    target_valid;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] command_x;
		logic signed [POS_W-1:0] command_y;
		logic signed [POS_W-1:0] command_z;
		logic                    in_deadband;
	} out_item_t;

	// Saturate a 41-bit sum to 40 bits
	function automatic logic signed [SUM_W-1:0] sat40(input logic signed [SUM_W:0] v);
		if (v[SUM_W] != v[SUM_W-1])
			return v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return v[SUM_W-1:0];
	endfunction

	// Saturate the wide PID sum to 32 bits
	function automatic logic signed [SMTH_W-1:0] sat32_pid(input logic signed [PID_W-1:0] v);
		if (&v[PID_W-1:SMTH_W-1] || ~|v[PID_W-1:SMTH_W-1])
			return v[SMTH_W-1:0];
		return v[PID_W-1] ? {1'b1, {(SMTH_W-1){1'b0}}} : {1'b0, {(SMTH_W-1){1'b1}}};
	endfunction

	// Saturate the filter update to 32 bits
	function automatic logic signed [SMTH_W-1:0] sat32_smth(input logic signed [34:0] v);
		if (&v[34:SMTH_W-1] || ~|v[34:SMTH_W-1])
			return v[SMTH_W-1:0];
		return v[34] ? {1'b1, {(SMTH_W-1){1'b0}}} : {1'b0, {(SMTH_W-1){1'b1}}};
	endfunction

	// Saturate feedforward plus filter output to 24 bits
	function automatic logic signed [POS_W-1:0] sat24(input logic signed [SMTH_W:0] v);
		if (&v[SMTH_W:POS_W-1] || ~|v[SMTH_W:POS_W-1])
			return v[POS_W-1:0];
		return v[SMTH_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
	endfunction

	// Round half up, shift right by 8
	function automatic logic signed [PID_W-1:0] rnd8(input logic signed [PROD_W-1:0] a);
		logic signed [PROD_W-1:0] t;
		t = (a + PROD_W'(128)) >>> 8;
		return t[PID_W-1:0];
	endfunction

	// Round half up, shift right by 16
	function automatic logic signed [PID_W-1:0] rnd16(input logic signed [PROD_W-1:0] a);
		logic signed [PROD_W-1:0] t;
		t = (a + PROD_W'(32768)) >>> 16;
		return t[PID_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/cpvc_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none
interface cpvc_in_if import cpvc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cpvc_out_if import cpvc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/cartesian_pid_velocity_command_core.sv =====
// Cartesian PID velocity command core: per-axis PID, low-pass filter, deadband and saturation.
//
// Usage:
// - in_item carries one control tick (targets, measurements, feedforward, enable,
//   target_valid); a transaction is taken when valid and ready are both high.
// - out_item carries the three-axis velocity command and the deadband flag.
// - cfg_we/cfg_index/cfg_data write the gains, filter coefficient and deadband;
//   write them only while the core is idle. Unknown indexes are ignored.
// - All products come from one bit-serial shift-add multiplier that retires one
//   multiplier bit per cycle and stops at the highest set bit. Per axis there are
//   five products (P, I, D, filter, error square), worked in turn after one setup step;
//   each product is followed by a post-processing step, and after the last axis the
//   result goes into the output register.
// - One item is processed at a time; in_item.ready is high while the core is idle,
//   also while an earlier result still waits in the output register.
// - If the receiver stalls, the finished result waits until the output register
//   frees up, and the next item is held off until then.
// - Reset restores the register defaults and clears the integrator, last error and
//   filter state on all axes; the output register comes up empty.
`default_nettype none
module cartesian_pid_velocity_command_core import cpvc_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]  cfg_data,
	cpvc_in_if.sink          in_item,
	cpvc_out_if.source       out_item
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_MUL   = 5'b00100,
		S_POST  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		OP_P,
		OP_I,
		OP_D,
		OP_F,
		OP_SQ
	} op_t;

	state_t state_q;
	op_t    op_q;

	// Configuration
	logic [15:0] kp_q, kd_q, alpha_q;
	logic [23:0] ki_q;
	logic [31:0] db_q;

	// Per-axis controller state
	logic signed [SUM_W-1:0]  esum_q  [AXES];
	logic signed [ERR_W-1:0]  lerr_q  [AXES];
	logic signed [SMTH_W-1:0] smth_q  [AXES];
	logic signed [POS_W-1:0]  cmd_q   [AXES];

	// Working registers
	in_item_t                 in_q;
	logic [AXIS_W-1:0]        axis_q;
	logic signed [ERR_W-1:0]  e_q;
	logic signed [DERR_W-1:0] de_q;
	logic signed [PID_W-1:0]  pid_q;
	logic [NORM_W-1:0]        norm_q;
	logic signed [PROD_W-1:0] mc_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [MUL_W-1:0]         ml_q;

	logic      out_valid_q;
	out_item_t out_q;

	// Per-axis views of the captured item
	logic signed [POS_W-1:0] tgt [AXES];
	logic signed [POS_W-1:0] meas [AXES];
	logic signed [POS_W-1:0] ffw [AXES];

	assign tgt[0]  = in_q.target_x;
	assign tgt[1]  = in_q.target_y;
	assign tgt[2]  = in_q.target_z;
	assign meas[0] = in_q.measured_x;
	assign meas[1] = in_q.measured_y;
	assign meas[2] = in_q.measured_z;
	assign ffw[0]  = in_q.feedforward_x;
	assign ffw[1]  = in_q.feedforward_y;
	assign ffw[2]  = in_q.feedforward_z;

	// Setup arithmetic for the current axis
	logic signed [ERR_W-1:0]  e_w;
	logic signed [DERR_W-1:0] de_w;
	logic signed [SUM_W-1:0]  sum_w;
	always_comb begin
		e_w   = in_q.target_valid ? (ERR_W'(tgt[axis_q]) - ERR_W'(meas[axis_q])) : '0;
		de_w  = DERR_W'(e_w) - DERR_W'(lerr_q[axis_q]);
		sum_w = sat40((SUM_W+1)'(esum_q[axis_q]) + (SUM_W+1)'(e_w));
	end

	// Post-processing of the finished product
	logic signed [PID_W-1:0]  pid_sum_w;
	logic signed [SMTH_W-1:0] pid_sat_w;
	logic signed [SMTH_W:0]   diff_w;
	logic signed [34:0]       smth_sum_w;
	logic signed [SMTH_W-1:0] smth_new_w;
	logic signed [POS_W-1:0]  cmd_w;
	logic [ERR_W-1:0]         e_abs_w;
	logic                     dead_w;
	always_comb begin
		pid_sum_w  = pid_q + rnd8(acc_q);
		pid_sat_w  = sat32_pid(pid_sum_w);
		diff_w     = (SMTH_W+1)'(pid_sat_w) - (SMTH_W+1)'(smth_q[axis_q]);
		smth_sum_w = 35'(smth_q[axis_q]) + 35'(rnd16(acc_q));
		smth_new_w = sat32_smth(smth_sum_w);
		cmd_w      = sat24((SMTH_W+1)'(ffw[axis_q]) + (SMTH_W+1)'(smth_new_w));
		e_abs_w    = e_q[ERR_W-1] ? ERR_W'(-e_q) : ERR_W'(e_q);
		dead_w     = norm_q < NORM_W'(db_q);
	end

	assign in_item.ready  = (state_q == S_IDLE);
	assign out_item.valid = out_valid_q;
	assign out_item.data  = out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= 16'd230;
			ki_q    <= 24'd0;
			kd_q    <= 16'd1280;
			alpha_q <= 16'd7314;
			db_q    <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:    kp_q    <= cfg_data[15:0];
				REG_KI:    ki_q    <= cfg_data[23:0];
				REG_KD:    kd_q    <= cfg_data[15:0];
				REG_ALPHA: alpha_q <= cfg_data[15:0];
				REG_DB:    db_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_P;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				esum_q[i] <= '0;
				lerr_q[i] <= '0;
				smth_q[i] <= '0;
			end
		end else begin
			// drained result; a reload in S_DONE sets the flag instead
			if (out_valid_q && out_item.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_item.valid) begin
						in_q    <= in_item.data;
						axis_q  <= '0;
						norm_q  <= '0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					e_q            <= e_w;
					de_q           <= de_w;
					esum_q[axis_q] <= sum_w;
					lerr_q[axis_q] <= e_w;
					mc_q           <= PROD_W'(e_w);
					ml_q           <= MUL_W'(kp_q);
					acc_q          <= '0;
					op_q           <= OP_P;
					state_q        <= S_MUL;
				end
				S_MUL: begin
					// one multiplier bit per cycle, LSB first
					if (ml_q == '0) begin
						state_q <= S_POST;
					end else begin
						if (ml_q[0])
							acc_q <= acc_q + mc_q;
						mc_q <= mc_q <<< 1;
						ml_q <= ml_q >> 1;
					end
				end
				S_POST: begin
					acc_q   <= '0;
					state_q <= S_MUL;
					case (op_q)
						OP_P: begin
							pid_q <= rnd8(acc_q);
							mc_q  <= PROD_W'(esum_q[axis_q]);
							ml_q  <= MUL_W'(ki_q);
							op_q  <= OP_I;
						end
						OP_I: begin
							pid_q <= pid_q + rnd16(acc_q);
							mc_q  <= PROD_W'(de_q);
							ml_q  <= MUL_W'(kd_q);
							op_q  <= OP_D;
						end
						OP_D: begin
							mc_q <= PROD_W'(diff_w);
							ml_q <= MUL_W'(alpha_q);
							op_q <= OP_F;
						end
						OP_F: begin
							smth_q[axis_q] <= smth_new_w;
							cmd_q[axis_q]  <= cmd_w;
							mc_q           <= PROD_W'($unsigned(e_abs_w));
							ml_q           <= e_abs_w;
							op_q           <= OP_SQ;
						end
						default: begin
							norm_q <= norm_q + acc_q[NORM_W-1:0];
							if (axis_q == AXIS_W'(AXES - 1)) begin
								state_q <= S_DONE;
							end else begin
								axis_q  <= axis_q + 1'b1;
								state_q <= S_SETUP;
							end
						end
					endcase
				end
				S_DONE: begin
					// wait for a free output register
					if (!out_valid_q || out_item.ready) begin
						out_q.in_deadband <= dead_w;
						out_q.command_x   <= (in_q.enable && !dead_w) ? cmd_q[0] : '0;
						out_q.command_y   <= (in_q.enable && !dead_w) ? cmd_q[1] : '0;
						out_q.command_z   <= (in_q.enable && !dead_w) ? cmd_q[2] : '0;
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/cpvc_checker.sv =====
// Port-level checker for the Cartesian PID velocity command core, bound into the core module.
`default_nettype none
module cpvc_checker import cpvc_pkg::*; (
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_ready,
	input wire            out_valid,
	input wire            out_ready,
	input wire out_item_t out_data
);

	// Result holds while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// Deadband forces a zero command
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_deadband |->
			out_data.command_x == '0 && out_data.command_y == '0 && out_data.command_z == '0)
		else $error("nonzero command inside deadband");

	// Core is busy right after taking a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while busy");

endmodule

bind cartesian_pid_velocity_command_core cpvc_checker u_cpvc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_item.valid),
	.in_ready (in_item.ready),
	.out_valid(out_item.valid),
	.out_ready(out_item.ready),
	.out_data (out_item.data)
);
`default_nettype wire
